// ----- rtl/assert_macros.svh -----
// assertion macros shared by the leader clustering rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lca_pkg.sv -----
// types and constants of the leader clustering block
`default_nettype none

package lca_pkg;

    localparam int VAL_W   = 24;   // one 20.4 value
    localparam int SUM_W   = 40;   // running sum of one element
    localparam int MEMB_W  = 16;   // member count
    localparam int DIST_W  = 32;   // l1 distance and its limit
    localparam int IDX_W   = 6;    // cluster_index field
    localparam int KEPT_W  = 5;    // kept_rows field
    localparam int IN_W    = 3 * VAL_W;
    localparam int OUT_W   = 64;
    localparam int CNT_W   = 5;    // divider step counter

    localparam logic [1:0] REG_AREA_THR = 2'd0;
    localparam logic [1:0] REG_AREA_TOL = 2'd1;
    localparam logic [1:0] REG_POS_TOL  = 2'd2;
    localparam logic [1:0] REG_DIST_LIM = 2'd3;

    typedef enum logic [1:0] {
        ST_JOIN = 2'd0,
        ST_NEW  = 2'd1,
        ST_FULL = 2'd2,
        ST_ROWS = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INFO,
        S_INFO_CHK,
        S_CMP,
        S_ROW_RD,
        S_ROW_DATA,
        S_DIV_GO,
        S_DIV_WAIT,
        S_WR,
        S_DECIDE,
        S_JOIN_CHK,
        S_INFO_WR
    } state_t;

    typedef enum logic [1:0] {
        M_SCAN,
        M_CHECK,
        M_UPD,
        M_NEW
    } mode_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [MEMB_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [VAL_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/leader_cluster_assign.sv -----
// top level of the leader clustering block: row buffer, cluster tables and sequencer
//
// leader_cluster_assign takes one feature row per beat (area, x, y in unsigned 20.4)
// and drops rows whose area is below area_threshold. kept rows go into a row buffer ram;
// rows past MAX_ROWS are ignored and flag the feature. a beat with tlast ends the feature
// and gives exactly one result beat. on the last row the sequencer walks the cluster
// table ram once; for every cluster of the same row count it reads each row from the
// sums ram and the row buffer and forms the three centre values one at a time through a
// shared 24-step divider, then compares the distance. the nearest qualifying cluster is
// walked again for the tolerance check, and the chosen or new cluster is written back
// row by row. all state sits in three single-write rams with registered reads; the walk
// handles one entry at a time and only one feature is in flight, so no access can overlap
// a pending write. the result sits in an output register; rows of the next feature are
// taken while it waits, a last row only once it has gone. configuration is to be written
// by the user only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module leader_cluster_assign #(
    parameter int MAX_CLUSTERS = 64,
    parameter int MAX_ROWS     = 16,
    parameter int MAX_MEMBERS  = 65535
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // row stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [lca_pkg::IN_W-1:0]   s_tdata,   // area, pos_x, pos_y
    input  wire logic                       s_tlast,   // last_row
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [lca_pkg::OUT_W-1:0]       m_tdata,   // status, cluster_index,
                                                       // cluster_members, best_distance,
                                                       // kept_rows, zero pad
    // configuration writes
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_addr,
    input  wire logic [lca_pkg::DIST_W-1:0] cfg_wdata
);

    localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CT_W   = $clog2(MAX_CLUSTERS + 1);
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RC_W   = $clog2(MAX_ROWS + 1);
    localparam int SDEP   = MAX_CLUSTERS * MAX_ROWS;
    localparam int SA_W   = (SDEP > 1) ? $clog2(SDEP) : 1;
    localparam int INFO_W = RC_W + lca_pkg::MEMB_W;
    localparam int SROW_W = 3 * lca_pkg::SUM_W;
    localparam int VW     = lca_pkg::VAL_W;
    localparam int SW     = lca_pkg::SUM_W;

    // configuration
    logic [VW-1:0]              thr_reg, thr_next;
    logic [VW-1:0]              atol_reg, atol_next;
    logic [VW-1:0]              ptol_reg, ptol_next;
    logic [lca_pkg::DIST_W-1:0] lim_reg, lim_next;

    // sequencer state
    lca_pkg::state_t            state_reg, state_next;
    lca_pkg::mode_t             mode_reg, mode_next;
    logic [CT_W-1:0]            c_reg, c_next;          // cluster being walked
    logic [CT_W-1:0]            total_reg, total_next;  // clusters in the table
    logic [RC_W-1:0]            r_reg, r_next;          // row being walked
    logic [1:0]                 k_reg, k_next;          // element of the row
    logic [RC_W-1:0]            row_cnt_reg, row_cnt_next;
    logic                       ovf_reg, ovf_next;
    logic [RC_W-1:0]            n_reg, n_next;          // rows of the feature
    logic [lca_pkg::DIST_W-1:0] d_reg, d_next;
    logic                       found_reg, found_next;
    logic [CT_W-1:0]            best_reg, best_next;
    logic [lca_pkg::DIST_W-1:0] best_d_reg, best_d_next;
    logic [lca_pkg::MEMB_W-1:0] best_m_reg, best_m_next;
    logic [lca_pkg::MEMB_W-1:0] cand_m_reg, cand_m_next;
    logic                       fail_reg, fail_next;
    logic [SROW_W-1:0]          sums_q_reg, sums_q_next;
    logic [lca_pkg::IN_W-1:0]   feat_q_reg, feat_q_next;

    // result register
    logic                       m_valid_reg, m_valid_next;
    logic [lca_pkg::OUT_W-1:0]  m_data_reg, m_data_next;

    // rams
    logic                       fb_we;
    logic [RI_W-1:0]            fb_waddr, fb_raddr;
    logic [lca_pkg::IN_W-1:0]   fb_rdata;
    logic                       sm_we;
    logic [SA_W-1:0]            sm_addr;
    logic [SROW_W-1:0]          sm_wdata, sm_rdata;
    logic                       in_we;
    logic [CL_W-1:0]            in_addr;
    logic [INFO_W-1:0]          in_wdata, in_rdata;

    lca_pkg::div_req_t          div_req;
    lca_pkg::div_rsp_t          div_rsp;

    // combinational helpers
    logic                       s_fire;
    logic                       go_new;
    logic                       go_idle;
    logic                       out_load;
    lca_pkg::status_t           out_status;
    logic [CT_W-1:0]            out_index;
    logic [lca_pkg::MEMB_W-1:0] out_members;
    logic [lca_pkg::DIST_W-1:0] out_dist;
    logic [31:0]                idx_wide;
    logic [31:0]                kept_wide;
    logic [VW-1:0]              feat_k;
    logic [SW-1:0]              sum_k;
    logic [VW-1:0]              diff;
    logic [lca_pkg::MEMB_W-1:0] new_members;
    logic [RC_W-1:0]            info_rows;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == lca_pkg::S_IDLE) && (!s_tlast || !m_valid_reg);

    assign fb_waddr = row_cnt_reg[RI_W-1:0];
    assign fb_raddr = r_reg[RI_W-1:0];
    assign sm_addr  = SA_W'(c_reg[CL_W-1:0]) * SA_W'(MAX_ROWS) + SA_W'(r_reg[RI_W-1:0]);
    assign in_addr  = c_reg[CL_W-1:0];
    assign info_rows = in_rdata[INFO_W-1:lca_pkg::MEMB_W];

    lca_ram #(.WIDTH(lca_pkg::IN_W), .DEPTH(MAX_ROWS)) u_rowbuf (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (s_tdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    lca_ram #(.WIDTH(SROW_W), .DEPTH(SDEP)) u_sums (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_addr),
        .wdata (sm_wdata),
        .raddr (sm_addr),
        .rdata (sm_rdata)
    );

    lca_ram #(.WIDTH(INFO_W), .DEPTH(MAX_CLUSTERS)) u_info (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_addr),
        .wdata (in_wdata),
        .raddr (in_addr),
        .rdata (in_rdata)
    );

    lca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // element k of the latched row
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                feat_k = feat_q_reg[VW-1:0];
                sum_k  = sums_q_reg[SW-1:0];
            end
            2'd1:
            begin
                feat_k = feat_q_reg[2*VW-1:VW];
                sum_k  = sums_q_reg[2*SW-1:SW];
            end
            default:
            begin
                feat_k = feat_q_reg[3*VW-1:2*VW];
                sum_k  = sums_q_reg[3*SW-1:2*SW];
            end
        endcase
        diff = (div_rsp.quotient > feat_k) ? (div_rsp.quotient - feat_k)
                                           : (feat_k - div_rsp.quotient);
    end

    // sums write data: accumulate on join, copy the row for a new cluster
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (mode_reg == lca_pkg::M_UPD)
            begin
                sm_wdata[i*SW +: SW] = sums_q_reg[i*SW +: SW] + SW'(feat_q_reg[i*VW +: VW]);
            end
            else
            begin
                sm_wdata[i*SW +: SW] = SW'(feat_q_reg[i*VW +: VW]);
            end
        end
    end

    assign new_members = (mode_reg == lca_pkg::M_UPD) ? best_m_reg + lca_pkg::MEMB_W'(1)
                                                      : lca_pkg::MEMB_W'(1);
    assign in_wdata    = {n_reg, new_members};

    always_comb
    begin
        thr_next     = thr_reg;
        atol_next    = atol_reg;
        ptol_next    = ptol_reg;
        lim_next     = lim_reg;
        state_next   = state_reg;
        mode_next    = mode_reg;
        c_next       = c_reg;
        total_next   = total_reg;
        r_next       = r_reg;
        k_next       = k_reg;
        row_cnt_next = row_cnt_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        best_d_next  = best_d_reg;
        best_m_next  = best_m_reg;
        cand_m_next  = cand_m_reg;
        fail_next    = fail_reg;
        sums_q_next  = sums_q_reg;
        feat_q_next  = feat_q_reg;
        fb_we        = 1'b0;
        sm_we        = 1'b0;
        in_we        = 1'b0;
        div_req      = '0;
        go_new       = 1'b0;
        go_idle      = 1'b0;
        out_load     = 1'b0;
        out_status   = lca_pkg::ST_JOIN;
        out_index    = '0;
        out_members  = '0;
        out_dist     = '0;

        if (cfg_we)
        begin
            case (cfg_addr)
                lca_pkg::REG_AREA_THR: thr_next  = cfg_wdata[VW-1:0];
                lca_pkg::REG_AREA_TOL: atol_next = cfg_wdata[VW-1:0];
                lca_pkg::REG_POS_TOL:  ptol_next = cfg_wdata[VW-1:0];
                lca_pkg::REG_DIST_LIM: lim_next  = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            lca_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tdata[VW-1:0] >= thr_reg)
                    begin
                        if (row_cnt_reg < RC_W'(MAX_ROWS))
                        begin
                            fb_we        = 1'b1;
                            row_cnt_next = row_cnt_reg + RC_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast)
                    begin
                        n_next     = row_cnt_next;
                        state_next = lca_pkg::S_START;
                    end
                end
            end

            lca_pkg::S_START:
            begin
                c_next     = '0;
                found_next = 1'b0;
                mode_next  = lca_pkg::M_SCAN;
                if (ovf_reg)
                begin
                    out_load   = 1'b1;
                    out_status = lca_pkg::ST_ROWS;
                    go_idle    = 1'b1;
                end
                else if (total_reg == '0)
                begin
                    state_next = lca_pkg::S_DECIDE;
                end
                else
                begin
                    state_next = lca_pkg::S_INFO;
                end
            end

            lca_pkg::S_INFO:
            begin
                state_next = lca_pkg::S_INFO_CHK;
            end

            lca_pkg::S_INFO_CHK:
            begin
                if (info_rows == n_reg)
                begin
                    cand_m_next = in_rdata[lca_pkg::MEMB_W-1:0];
                    d_next      = '0;
                    r_next      = '0;
                    state_next  = (n_reg == '0) ? lca_pkg::S_CMP : lca_pkg::S_ROW_RD;
                end
                else if (c_reg + CT_W'(1) == total_reg)
                begin
                    state_next = lca_pkg::S_DECIDE;
                end
                else
                begin
                    c_next     = c_reg + CT_W'(1);
                    state_next = lca_pkg::S_INFO;
                end
            end

            lca_pkg::S_ROW_RD:
            begin
                state_next = lca_pkg::S_ROW_DATA;
            end

            lca_pkg::S_ROW_DATA:
            begin
                sums_q_next = sm_rdata;
                feat_q_next = fb_rdata;
                k_next      = '0;
                if (mode_reg == lca_pkg::M_SCAN || mode_reg == lca_pkg::M_CHECK)
                begin
                    state_next = lca_pkg::S_DIV_GO;
                end
                else
                begin
                    state_next = lca_pkg::S_WR;
                end
            end

            lca_pkg::S_DIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = sum_k;
                div_req.divisor  = (mode_reg == lca_pkg::M_SCAN) ? cand_m_reg : best_m_reg;
                state_next       = lca_pkg::S_DIV_WAIT;
            end

            lca_pkg::S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (mode_reg == lca_pkg::M_SCAN)
                    begin
                        d_next = d_reg + lca_pkg::DIST_W'(diff);
                    end
                    else if (diff > ((k_reg == 2'd0) ? atol_reg : ptol_reg))
                    begin
                        fail_next = 1'b1;
                    end
                    if (k_reg == 2'd2)
                    begin
                        if (r_reg + RC_W'(1) == n_reg)
                        begin
                            state_next = (mode_reg == lca_pkg::M_SCAN) ? lca_pkg::S_CMP
                                                                       : lca_pkg::S_JOIN_CHK;
                        end
                        else
                        begin
                            r_next     = r_reg + RC_W'(1);
                            state_next = lca_pkg::S_ROW_RD;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = lca_pkg::S_DIV_GO;
                    end
                end
            end

            lca_pkg::S_CMP:
            begin
                // strictly nearer wins, so a tie keeps the lower index
                if (d_reg < lim_reg && (!found_reg || d_reg < best_d_reg))
                begin
                    found_next  = 1'b1;
                    best_next   = c_reg;
                    best_d_next = d_reg;
                    best_m_next = cand_m_reg;
                end
                if (c_reg + CT_W'(1) == total_reg)
                begin
                    state_next = lca_pkg::S_DECIDE;
                end
                else
                begin
                    c_next     = c_reg + CT_W'(1);
                    state_next = lca_pkg::S_INFO;
                end
            end

            lca_pkg::S_DECIDE:
            begin
                if (found_reg)
                begin
                    mode_next  = lca_pkg::M_CHECK;
                    c_next     = best_reg;
                    r_next     = '0;
                    fail_next  = 1'b0;
                    state_next = (n_reg == '0) ? lca_pkg::S_JOIN_CHK : lca_pkg::S_ROW_RD;
                end
                else
                begin
                    go_new = 1'b1;
                end
            end

            lca_pkg::S_JOIN_CHK:
            begin
                if (!fail_reg && best_m_reg < lca_pkg::MEMB_W'(MAX_MEMBERS))
                begin
                    mode_next  = lca_pkg::M_UPD;
                    c_next     = best_reg;
                    r_next     = '0;
                    state_next = (n_reg == '0) ? lca_pkg::S_INFO_WR : lca_pkg::S_ROW_RD;
                end
                else
                begin
                    go_new = 1'b1;
                end
            end

            lca_pkg::S_WR:
            begin
                sm_we = 1'b1;
                if (r_reg + RC_W'(1) == n_reg)
                begin
                    state_next = lca_pkg::S_INFO_WR;
                end
                else
                begin
                    r_next     = r_reg + RC_W'(1);
                    state_next = lca_pkg::S_ROW_RD;
                end
            end

            lca_pkg::S_INFO_WR:
            begin
                in_we       = 1'b1;
                out_load    = 1'b1;
                out_index   = c_reg;
                out_members = new_members;
                if (mode_reg == lca_pkg::M_UPD)
                begin
                    out_status = lca_pkg::ST_JOIN;
                    out_dist   = best_d_reg;
                end
                else
                begin
                    out_status = lca_pkg::ST_NEW;
                    total_next = total_reg + CT_W'(1);
                end
                go_idle = 1'b1;
            end

            default:
            begin
                state_next = lca_pkg::S_IDLE;
            end
        endcase

        // new cluster at the end of the table, or drop when it is full
        if (go_new)
        begin
            if (total_reg >= CT_W'(MAX_CLUSTERS))
            begin
                out_load   = 1'b1;
                out_status = lca_pkg::ST_FULL;
                go_idle    = 1'b1;
            end
            else
            begin
                mode_next  = lca_pkg::M_NEW;
                c_next     = total_reg;
                r_next     = '0;
                state_next = (n_reg == '0) ? lca_pkg::S_INFO_WR : lca_pkg::S_ROW_RD;
            end
        end

        if (go_idle)
        begin
            state_next   = lca_pkg::S_IDLE;
            row_cnt_next = '0;
            ovf_next     = 1'b0;
        end
    end

    // result beat
    always_comb
    begin
        idx_wide     = 32'(out_index);
        kept_wide    = 32'(n_reg);
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000,
                            kept_wide[lca_pkg::KEPT_W-1:0],
                            out_dist,
                            out_members,
                            idx_wide[lca_pkg::IDX_W-1:0],
                            out_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= '0;
            atol_reg    <= '1;
            ptol_reg    <= '1;
            lim_reg     <= lca_pkg::DIST_W'(16000000);
            state_reg   <= lca_pkg::S_IDLE;
            mode_reg    <= lca_pkg::M_SCAN;
            total_reg   <= '0;
            row_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            found_reg   <= 1'b0;
            fail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            thr_reg     <= thr_next;
            atol_reg    <= atol_next;
            ptol_reg    <= ptol_next;
            lim_reg     <= lim_next;
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            total_reg   <= total_next;
            row_cnt_reg <= row_cnt_next;
            ovf_reg     <= ovf_next;
            found_reg   <= found_next;
            fail_reg    <= fail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg      <= c_next;
        r_reg      <= r_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        best_reg   <= best_next;
        best_d_reg <= best_d_next;
        best_m_reg <= best_m_next;
        cand_m_reg <= cand_m_next;
        sums_q_reg <= sums_q_next;
        feat_q_reg <= feat_q_next;
        m_data_reg <= m_data_next;
    end

    `LCA_ASSERT_NOW(a_total_max, 1'b1, total_reg <= CT_W'(MAX_CLUSTERS), "cluster table overrun")
    `LCA_ASSERT_NOW(a_rows_max, 1'b1, row_cnt_reg <= RC_W'(MAX_ROWS), "row buffer overrun")
    `LCA_ASSERT_NOW(a_join_room, in_we && mode_reg == lca_pkg::M_UPD,
        best_m_reg < lca_pkg::MEMB_W'(MAX_MEMBERS), "join into a full cluster")
    `LCA_ASSERT_NEXT(a_last_busy, s_fire && s_tlast, state_reg != lca_pkg::S_IDLE,
        "last row did not start the walk")

endmodule

`default_nettype wire

// ----- rtl/lca_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/lca_div.sv -----
// restoring divider, one quotient bit per cycle, for the cluster centres
`default_nettype none
`include "assert_macros.svh"

module lca_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lca_pkg::div_req_t req,
    output lca_pkg::div_rsp_t      rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [lca_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [lca_pkg::MEMB_W-1:0]     rem_reg, rem_next;
    logic [lca_pkg::MEMB_W-1:0]     dvs_reg, dvs_next;
    logic [lca_pkg::VAL_W-1:0]      quo_reg, quo_next;
    logic [lca_pkg::MEMB_W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[lca_pkg::VAL_W-1]};
        if (req.start)
        begin
            // high part is below the divisor for any valid cluster
            busy_next = 1'b1;
            cnt_next  = lca_pkg::CNT_W'(lca_pkg::VAL_W);
            rem_next  = req.dividend[lca_pkg::SUM_W-1:lca_pkg::VAL_W];
            quo_next  = req.dividend[lca_pkg::VAL_W-1:0];
            dvs_next  = (req.divisor == '0) ? lca_pkg::MEMB_W'(1) : req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = lca_pkg::MEMB_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[lca_pkg::VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[lca_pkg::MEMB_W-1:0];
                quo_next = {quo_reg[lca_pkg::VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - lca_pkg::CNT_W'(1);
            if (cnt_reg == lca_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `LCA_ASSERT_NOW(a_start_idle, req.start, !busy_reg, "divider started while busy")
    `LCA_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "divider done while still busy")
    `LCA_ASSERT_NEXT(a_done_ends, done_reg, !done_reg && !busy_reg, "divider done held")

endmodule

`default_nettype wire

// ----- tb/sv/lca_checker.sv -----
// result checker for leader_cluster_assign: watches the row, result and config ports
`default_nettype none

module lca_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    input  wire logic                       s_tready,
    input  wire logic [lca_pkg::IN_W-1:0]   s_tdata,
    input  wire logic                       s_tlast,
    input  wire logic                       m_tvalid,
    input  wire logic                       m_tready,
    input  wire logic [lca_pkg::OUT_W-1:0]  m_tdata,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_addr,
    input  wire logic [lca_pkg::DIST_W-1:0] cfg_wdata,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCL  = 64;
    localparam int NROW = 16;
    localparam int NMEM = 65535;

    typedef struct {
        lca_pkg::status_t            status;
        logic [lca_pkg::IDX_W-1:0]   index;
        logic [lca_pkg::MEMB_W-1:0]  members;
        logic [lca_pkg::DIST_W-1:0]  distance;
        logic [lca_pkg::KEPT_W-1:0]  kept;
    } cluster_result_t;

    // own copy of the block state
    logic [lca_pkg::VAL_W-1:0]  thr, area_tol, pos_tol;
    logic [lca_pkg::DIST_W-1:0] dist_lim;
    logic [lca_pkg::SUM_W-1:0]  sums [NCL][NROW][3];
    int                         row_cnt [NCL];
    int                         memb_cnt [NCL];
    int                         total;
    logic [lca_pkg::VAL_W-1:0]  rowbuf [NROW][3];
    int                         nrows;
    bit                         overflow;

    cluster_result_t            expected_results[$];

    function automatic logic [31:0] centre(int c, int r, int k);
        logic [lca_pkg::SUM_W-1:0] n;
        n = (memb_cnt[c] == 0) ? 1 : memb_cnt[c];
        return 32'(sums[c][r][k] / n);
    endfunction

    function automatic logic [31:0] adiff(logic [31:0] a, logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // one accepted row beat; a last row queues one result
    function automatic void assign_row(logic [lca_pkg::VAL_W-1:0] a,
                                       logic [lca_pkg::VAL_W-1:0] x,
                                       logic [lca_pkg::VAL_W-1:0] y, bit last);
        cluster_result_t res;
        bit              found, join_ok;
        int              best;
        logic [63:0]     d, best_d;
        if (a >= thr) begin
            if (nrows < NROW) begin
                rowbuf[nrows][0] = a;
                rowbuf[nrows][1] = x;
                rowbuf[nrows][2] = y;
                nrows++;
            end
            else
                overflow = 1;
        end
        if (!last)
            return;
        res = '{lca_pkg::ST_JOIN, '0, '0, '0, lca_pkg::KEPT_W'(nrows)};
        found = 0;
        join_ok = 0;
        best = 0;
        best_d = 0;
        if (overflow)
            res.status = lca_pkg::ST_ROWS;
        else
        begin
            for (int c = 0; c < total; c++) begin
                if (row_cnt[c] != nrows)
                    continue;
                d = 0;
                for (int r = 0; r < nrows; r++)
                    for (int k = 0; k < 3; k++)
                        d += adiff(centre(c, r, k), 32'(rowbuf[r][k]));
                if (d < 64'(dist_lim) && (!found || d < best_d)) begin
                    found = 1;
                    best = c;
                    best_d = d;
                end
            end
            if (found) begin
                join_ok = 1;
                for (int r = 0; r < nrows; r++)
                    if (adiff(centre(best, r, 0), 32'(rowbuf[r][0])) > 32'(area_tol) ||
                        adiff(centre(best, r, 1), 32'(rowbuf[r][1])) > 32'(pos_tol) ||
                        adiff(centre(best, r, 2), 32'(rowbuf[r][2])) > 32'(pos_tol))
                        join_ok = 0;
                if (memb_cnt[best] >= NMEM)
                    join_ok = 0;
            end
            if (join_ok) begin
                for (int r = 0; r < nrows; r++)
                    for (int k = 0; k < 3; k++)
                        sums[best][r][k] += lca_pkg::SUM_W'(rowbuf[r][k]);
                memb_cnt[best]++;
                res.status = lca_pkg::ST_JOIN;
                res.index = lca_pkg::IDX_W'(best);
                res.members = lca_pkg::MEMB_W'(memb_cnt[best]);
                res.distance = (best_d > 64'hFFFF_FFFF) ? '1 : best_d[31:0];
            end
            else if (total >= NCL)
                res.status = lca_pkg::ST_FULL;
            else
            begin
                for (int r = 0; r < nrows; r++)
                    for (int k = 0; k < 3; k++)
                        sums[total][r][k] = lca_pkg::SUM_W'(rowbuf[r][k]);
                row_cnt[total] = nrows;
                memb_cnt[total] = 1;
                res.status = lca_pkg::ST_NEW;
                res.index = lca_pkg::IDX_W'(total);
                res.members = 1;
                total++;
            end
        end
        expected_results = {expected_results, res};
        nrows = 0;
        overflow = 0;
    endfunction

    function automatic void compare_result(logic [lca_pkg::OUT_W-1:0] data);
        cluster_result_t exp_r;
        bit              bad;
        if (expected_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat %h", data);
            return;
        end
        exp_r = expected_results.pop_front();
        bad = (data[1:0] != exp_r.status) || (data[7:2] != exp_r.index) ||
              (data[23:8] != exp_r.members) || (data[55:24] != exp_r.distance) ||
              (data[60:56] != exp_r.kept);
        if (bad) begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: expected st %0d idx %0d mem %0d dist %0d kept %0d,",
                          " got st %0d idx %0d mem %0d dist %0d kept %0d"},
                         exp_r.status, exp_r.index, exp_r.members, exp_r.distance,
                         exp_r.kept, data[1:0], data[7:2], data[23:8], data[55:24],
                         data[60:56]);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thr <= '0;
            area_tol <= '1;
            pos_tol <= '1;
            dist_lim <= 32'd16000000;
            total = 0;
            nrows = 0;
            overflow = 0;
            errors = 0;
            pending <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                case (cfg_addr)
                    lca_pkg::REG_AREA_THR: thr <= cfg_wdata[lca_pkg::VAL_W-1:0];
                    lca_pkg::REG_AREA_TOL: area_tol <= cfg_wdata[lca_pkg::VAL_W-1:0];
                    lca_pkg::REG_POS_TOL:  pos_tol <= cfg_wdata[lca_pkg::VAL_W-1:0];
                    lca_pkg::REG_DIST_LIM: dist_lim <= cfg_wdata;
                    default: ;
                endcase
            if (s_tvalid && s_tready)
                assign_row(s_tdata[23:0], s_tdata[47:24], s_tdata[71:48], s_tlast);
            if (m_tvalid && m_tready)
                compare_result(m_tdata);
            pending <= expected_results.size();
        end
    end
endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// top of the leader_cluster_assign testbench: clock, reset, stimulus and verdict
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // longest stretch with no beat on either side before giving up
    localparam int STALL_LIMIT = 500000;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [lca_pkg::IN_W-1:0]   s_tdata;    // area, pos_x, pos_y
    logic                       s_tlast;    // last_row
    logic                       m_tvalid;
    logic                       m_tready;
    logic [lca_pkg::OUT_W-1:0]  m_tdata;    // status, cluster_index, cluster_members,
                                            // best_distance, kept_rows, zero pad
    logic                       cfg_we;
    logic [1:0]                 cfg_addr;
    logic [lca_pkg::DIST_W-1:0] cfg_wdata;
    int                         errors;
    int                         pending;

    bit                         steady;      // no idling on either side while set
    int                         hold_token;  // bumped to ask the receiver for a long hold-off
    int                         hold_seen;
    int                         hold_cnt;
    int                         quiet;       // cycles since the last beat
    logic [lca_pkg::VAL_W-1:0]  base [4][3];

    leader_cluster_assign i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    lca_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random back-pressure, or a long hold-off when asked
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            hold_seen <= hold_token;
            hold_cnt <= 0;
        end
        else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_cnt <= 2500;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // watchdog on cycles without any beat
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // one row beat; ready is taken at the falling edge, so the handshake is the next edge
    task automatic send_row(logic [lca_pkg::VAL_W-1:0] a, logic [lca_pkg::VAL_W-1:0] x,
                            logic [lca_pkg::VAL_W-1:0] y, bit last);
        bit rdy;
        if (!steady)
            while ($urandom_range(0, 99) < 28) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x, a};
        s_tlast <= last;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
    endtask

    // sender pauses until every result is in, plus a margin for trailing work
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [lca_pkg::DIST_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [lca_pkg::VAL_W-1:0] near(logic [lca_pkg::VAL_W-1:0] v,
                                                       int spread);
        int unsigned t;
        t = v + $urandom_range(0, spread);
        return (t > 24'hFFFFFF) ? 24'hFFFFFF : lca_pkg::VAL_W'(t);
    endfunction

    // feature of n rows, each close to one of the seed points
    task automatic send_feature(int n, int spread);
        int b;
        b = $urandom_range(0, 3);
        for (int r = 0; r < n; r++)
            send_row(near(base[(b + r) % 4][0], spread), near(base[(b + r) % 4][1], spread),
                     near(base[(b + r) % 4][2], spread), r == n - 1);
    endtask

    task automatic new_seeds();
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                base[i][k] = lca_pkg::VAL_W'($urandom);
    endtask

    initial
    begin
        int rows_sent;
        int pick;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = lca_pkg::REG_AREA_THR;
        cfg_wdata = '0;
        steady = 1'b0;
        hold_token = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, empty table, extremes, join at zero distance
        send_row('0, '0, '0, 1'b1);                          // empty table, cluster 0
        send_row('1, '1, '1, 1'b1);                          // beyond distance limit
        send_row('1, '1, '1, 1'b1);                          // joins at distance 0
        send_row(24'h000100, 24'h000200, 24'h000300, 1'b0);
        send_row(24'h000400, 24'h000500, 24'h000600, 1'b1);  // two rows
        for (int r = 0; r < 18; r++)                         // too many rows
            send_row(24'h000010, 24'h000020, 24'h000030, r == 17);
        drain();

        // everything below the threshold: zero kept rows, then a row at the top value
        write_reg(lca_pkg::REG_AREA_THR, 32'h00FFFFFF);
        send_row(24'hFFFFFE, 24'h123456, 24'h654321, 1'b1);  // no rows, new cluster
        send_row('0, '1, '1, 1'b1);                          // no rows, joins it
        send_row('1, '0, '0, 1'b1);
        drain();

        // zero tolerances: rows one step or more off their nearest cluster start new clusters
        write_reg(lca_pkg::REG_AREA_THR, 32'h0);
        write_reg(lca_pkg::REG_AREA_TOL, 32'h0);
        write_reg(lca_pkg::REG_POS_TOL, 32'h0);
        write_reg(lca_pkg::REG_DIST_LIM, 32'hFFFFFFFF);
        send_row(24'h000400, 24'h000500, 24'h000600, 1'b1);
        send_row(24'h000400, 24'h000501, 24'h000600, 1'b1);
        send_row(24'h000401, 24'h000500, 24'h000600, 1'b1);
        send_row(24'h0003FF, 24'h000500, 24'h0005FF, 1'b1);
        drain();

        // random features under several settings
        rows_sent = 0;
        for (int ph = 0; ph < 5 && rows_sent < 240; ph++) begin
            new_seeds();
            write_reg(lca_pkg::REG_AREA_THR,
                      (ph == 4) ? 32'h0 : 32'($urandom_range(0, 24'h3FFFFF)));
            write_reg(lca_pkg::REG_AREA_TOL,
                      (ph == 1) ? 32'hFFFFFF : 32'($urandom_range(0, 200)));
            write_reg(lca_pkg::REG_POS_TOL,
                      (ph == 2) ? 32'hFFFFFF : 32'($urandom_range(0, 200)));
            write_reg(lca_pkg::REG_DIST_LIM,
                      (ph == 3) ? 32'hFFFFFFFF : 32'($urandom_range(50, 2000)));
            steady = (ph == 2);
            if (ph == 1)
                hold_token++;                                // receiver holds, rows pile up
            for (int f = 0; f < 12; f++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    pick = $urandom_range(1, 3);
                    send_feature(pick, 150);
                    rows_sent += pick;
                end
                else if (pick < 88) begin
                    pick = $urandom_range(4, 16);
                    send_feature(pick, 150);
                    rows_sent += pick;
                end
                else if (pick < 93) begin
                    pick = $urandom_range(17, 19);
                    send_feature(pick, 150);
                    rows_sent += pick;
                end
                else
                begin
                    send_row(lca_pkg::VAL_W'($urandom), lca_pkg::VAL_W'($urandom),
                             lca_pkg::VAL_W'($urandom), 1'b1);
                    rows_sent++;
                end
            end
            drain();
        end
        steady = 1'b0;

        // fill the table with zero-row features that never qualify, then overflow it
        write_reg(lca_pkg::REG_AREA_THR, 32'h00FFFFFF);
        write_reg(lca_pkg::REG_DIST_LIM, 32'h0);
        for (int f = 0; f < 70; f++)
            send_row(lca_pkg::VAL_W'($urandom_range(0, 24'hFFFFFE)),
                     lca_pkg::VAL_W'($urandom), lca_pkg::VAL_W'($urandom), 1'b1);
        drain();

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
